/* rtl/nps_pkg.sv */
// Shared types, constants and helper functions for the noisy pendulum step unit.
// Depends on nothing; every other file in rtl/ imports it.
package nps_pkg;

    // Default fixed-point format and CORDIC length.
    localparam int FRAC_BITS_DEF       = 16;
    localparam int SINE_ITERATIONS_DEF = 16;

    // Datapath widths.
    localparam int STATE_W     = 32;  // angle, velocity, noise phase
    localparam int COUNT_W     = 20;  // step counter and step limit
    localparam int PROD_W      = 52;  // scaled product out of the shared multiplier
    localparam int MUL_A_W     = 34;  // signed multiplier operand A
    localparam int MUL_B_W     = 33;  // signed multiplier operand B
    localparam int ARG_W       = 33;  // angle plus noise phase
    localparam int MOD_W       = 34;  // offset argument during reduction
    localparam int FOLD_W      = 35;  // signed argument while folding
    localparam int CORDIC_W    = 33;  // CORDIC x, y and z, Q30
    localparam int CNT_W       = 5;   // iteration counter, at most 30 steps
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam int GAIN_W  = 31;
    localparam int DT_W    = 17;
    localparam int SCALE_W = 31;
    localparam int NOISE_W = 20;

    // Pi in Q60 and the CORDIC gain constant in Q30.
    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
    localparam logic signed [CORDIC_W-1:0] CORDIC_K_Q30 = 33'sd652032874;

    // Register reset values.
    localparam logic [GAIN_W-1:0]          GAIN_SQUARED_RST = 31'd16384;
    localparam logic [DT_W-1:0]            TIME_STEP_RST    = 17'd6554;
    localparam logic [SCALE_W-1:0]         NOISE_SCALE_RST  = 31'd2072;
    localparam logic signed [STATE_W-1:0]  INIT_ANGLE_RST   = 32'sd102944;
    localparam logic signed [STATE_W-1:0]  INIT_VEL_RST     = 32'sd0;
    localparam logic signed [STATE_W-1:0]  INIT_NOISE_RST   = 32'sd0;
    localparam logic [COUNT_W-1:0]         STEP_LIMIT_RST   = 20'd10000;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GAIN_SQUARED        = 3'd0,
        REG_TIME_STEP           = 3'd1,
        REG_NOISE_SCALE         = 3'd2,
        REG_INITIAL_ANGLE       = 3'd3,
        REG_INITIAL_VELOCITY    = 3'd4,
        REG_INITIAL_NOISE_PHASE = 3'd5,
        REG_STEP_LIMIT          = 3'd6
    } cfg_reg_t;

    typedef enum logic {
        ACT_RESTART = 1'b0,
        ACT_STEP    = 1'b1
    } action_t;

    typedef struct packed {
        logic                       action;
        logic signed [NOISE_W-1:0]  noise_sample;
    } in_item_t;

    typedef struct packed {
        logic signed [STATE_W-1:0]  angle;
        logic signed [STATE_W-1:0]  velocity;
        logic signed [STATE_W-1:0]  noise_phase;
        logic [COUNT_W-1:0]         step_count;
        logic                       done_res;
    } out_item_t;

    // Status of the sine unit toward the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } sine_stat_t;

    // Clamp a wide signed sum to the signed 32-bit range.
    function automatic logic signed [STATE_W-1:0] sat32(input logic signed [PROD_W:0] sum);
        logic signed [STATE_W-1:0] res;
        if (sum > 53'sd2147483647) begin
            res = 32'sh7FFF_FFFF;
        end else if (sum < -53'sd2147483648) begin
            res = 32'sh8000_0000;
        end else begin
            res = sum[STATE_W-1:0];
        end
        return res;
    endfunction

    // Arctangent of 2^-i in Q30.
    function automatic logic [29:0] atan_q30(input logic [CNT_W-1:0] i);
        logic [29:0] v;
        case (i)
            5'd0:    v = 30'd843314857;
            5'd1:    v = 30'd497837829;
            5'd2:    v = 30'd263043837;
            5'd3:    v = 30'd133525159;
            5'd4:    v = 30'd67021687;
            5'd5:    v = 30'd33543516;
            5'd6:    v = 30'd16775851;
            5'd7:    v = 30'd8388437;
            5'd8:    v = 30'd4194283;
            5'd9:    v = 30'd2097149;
            5'd10:   v = 30'd1048576;
            5'd11:   v = 30'd524288;
            5'd12:   v = 30'd262144;
            5'd13:   v = 30'd131072;
            5'd14:   v = 30'd65536;
            5'd15:   v = 30'd32768;
            5'd16:   v = 30'd16384;
            5'd17:   v = 30'd8192;
            5'd18:   v = 30'd4096;
            5'd19:   v = 30'd2048;
            5'd20:   v = 30'd1024;
            5'd21:   v = 30'd512;
            5'd22:   v = 30'd256;
            5'd23:   v = 30'd128;
            5'd24:   v = 30'd64;
            5'd25:   v = 30'd32;
            5'd26:   v = 30'd16;
            5'd27:   v = 30'd8;
            5'd28:   v = 30'd4;
            5'd29:   v = 30'd2;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

/* rtl/nps_mul.sv */
// Shared signed multiplier with a registered, fraction-scaled product.
// Depends on nps_pkg.
module nps_mul #(
    parameter int FRAC_BITS = nps_pkg::FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic signed [nps_pkg::MUL_A_W-1:0]   op_a,
    input  logic signed [nps_pkg::MUL_B_W-1:0]   op_b,
    output logic signed [nps_pkg::PROD_W-1:0]    prod
);
    import nps_pkg::*;

    localparam int FULL_W = MUL_A_W + MUL_B_W;

    logic signed [FULL_W-1:0] full;
    logic signed [FULL_W-1:0] scaled;
    logic signed [PROD_W-1:0] prod_reg;

    // Scale back by an arithmetic shift: rounds toward minus infinity.
    assign full   = op_a * op_b;
    assign scaled = full >>> FRAC_BITS;

    always_ff @(posedge clk)
    begin
        prod_reg <= scaled[PROD_W-1:0];
    end

    assign prod = prod_reg;

endmodule

/* rtl/nps_sine.sv */
// Iterative sine unit: modulo-2pi reduction by shifted compare-subtract, fold,
// then a rotation-mode CORDIC. Depends on nps_pkg.
module nps_sine #(
    parameter int FRAC_BITS       = nps_pkg::FRAC_BITS_DEF,
    parameter int SINE_ITERATIONS = nps_pkg::SINE_ITERATIONS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic signed [nps_pkg::ARG_W-1:0]     arg,
    output nps_pkg::sine_stat_t                  stat,
    output logic signed [nps_pkg::STATE_W-1:0]   sine
);
    import nps_pkg::*;

    localparam logic [63:0] PI_QF   = (PI_Q60 + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
    localparam logic [63:0] HALF_QF = (PI_Q60 + (64'd1 << (60 - FRAC_BITS))) >> (61 - FRAC_BITS);
    localparam logic [63:0] TWO_PI  = PI_QF << 1;
    // Smallest multiple of 2pi that makes any argument non-negative.
    localparam logic [63:0] OFFSET  = ((64'd1 << 32) + TWO_PI - 64'd1) / TWO_PI * TWO_PI;
    localparam int          TP_LEN  = $clog2(TWO_PI + 64'd1);
    localparam int          RED_STEPS = MOD_W + 1 - TP_LEN;
    localparam logic [63:0] DIV_INIT  = TWO_PI << (RED_STEPS - 1);
    localparam int          Q_SHIFT   = 30 - FRAC_BITS;

    localparam logic signed [FOLD_W-1:0] PI_S   = FOLD_W'(PI_QF);
    localparam logic signed [FOLD_W-1:0] HALF_S = FOLD_W'(HALF_QF);
    localparam logic signed [FOLD_W-1:0] TPI_S  = FOLD_W'(TWO_PI);

    typedef enum logic [3:0] {
        SN_IDLE   = 4'b0001,
        SN_REDUCE = 4'b0010,
        SN_FOLD   = 4'b0100,
        SN_ROTATE = 4'b1000
    } sn_state_t;

    sn_state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;

    logic [MOD_W-1:0]           u_reg;
    logic [MOD_W-1:0]           div_reg;
    logic signed [CORDIC_W-1:0] x_reg, y_reg, z_reg;

    logic [FOLD_W-1:0]          u_start;
    logic signed [FOLD_W-1:0]   r_fold;
    logic signed [FOLD_W-1:0]   z_wide;
    logic signed [CORDIC_W-1:0] dx, dy, atan_s;
    logic                       last_rot;

    assign u_start = FOLD_W'({{(FOLD_W - ARG_W){arg[ARG_W-1]}}, arg}) + FOLD_W'(OFFSET);

    // Fold the reduced argument into [-pi/2, pi/2].
    always_comb
    begin
        r_fold = FOLD_W'(u_reg);
        if (r_fold >= PI_S) begin
            r_fold = r_fold - TPI_S;
        end
        if (r_fold > HALF_S) begin
            r_fold = PI_S - r_fold;
        end else if (r_fold < -HALF_S) begin
            r_fold = -PI_S - r_fold;
        end
        z_wide = r_fold <<< Q_SHIFT;
    end

    assign dx       = y_reg >>> cnt_reg;
    assign dy       = x_reg >>> cnt_reg;
    assign atan_s   = CORDIC_W'(atan_q30(cnt_reg));
    assign last_rot = (cnt_reg == CNT_W'(SINE_ITERATIONS - 1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            SN_IDLE:   if (start) state_next = SN_REDUCE;
            SN_REDUCE: if (cnt_reg == '0) state_next = SN_FOLD;
            SN_FOLD:   state_next = SN_ROTATE;
            SN_ROTATE: if (last_rot) state_next = SN_IDLE;
            default:   state_next = SN_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= SN_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= (state_reg == SN_ROTATE) && last_rot;
            unique case (state_reg)
                SN_IDLE:   cnt_reg <= CNT_W'(RED_STEPS - 1);
                SN_REDUCE: cnt_reg <= cnt_reg - CNT_W'(1);
                SN_FOLD:   cnt_reg <= '0;
                SN_ROTATE: cnt_reg <= cnt_reg + CNT_W'(1);
                default:   cnt_reg <= '0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            SN_IDLE:
            begin
                if (start) begin
                    u_reg   <= u_start[MOD_W-1:0];
                    div_reg <= DIV_INIT[MOD_W-1:0];
                end
            end
            SN_REDUCE:
            begin
                if (u_reg >= div_reg) begin
                    u_reg <= u_reg - div_reg;
                end
                div_reg <= div_reg >> 1;
            end
            SN_FOLD:
            begin
                x_reg <= CORDIC_K_Q30;
                y_reg <= '0;
                z_reg <= z_wide[CORDIC_W-1:0];
            end
            SN_ROTATE:
            begin
                if (!z_reg[CORDIC_W-1]) begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - atan_s;
                end else begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + atan_s;
                end
            end
            default:
            begin
                u_reg <= u_reg;
            end
        endcase
    end

    logic signed [CORDIC_W-1:0] y_scaled;
    assign y_scaled = y_reg >>> Q_SHIFT;

    assign sine      = y_scaled[STATE_W-1:0];
    assign stat.busy = (state_reg != SN_IDLE);
    assign stat.done = done_reg;

endmodule

/* rtl/noisy_pendulum_symplectic_step_unit.sv */
// Top level of the noisy pendulum step unit: sequencer, pendulum state, registers.
// Depends on nps_pkg, nps_mul and nps_sine.
//
// One item in, one result item out. A restart item (action 0) loads the initial
// angle, velocity and noise phase and clears the step count; its result goes
// straight to the write state. A step item (action 1) updates noise phase, angle
// and velocity in that order with saturation; a step taken once the count has
// reached step_limit changes nothing and returns done_res = 1, also by way of
// the write state. A working step holds in the sine wait state until the sine
// unit is done, and any item holds in the write state while a stalled result
// still fills the output register. RED_STEPS is 35 minus the bit length of
// 2*pi in the chosen format, 16 for FRAC_BITS = 16: one compare-subtract per
// cycle reduces the argument modulo 2*pi, then one CORDIC iteration per cycle
// forms the sine. All four products go through one shared multiplier. The input
// is stalled for the whole time an item is at work; a finished result waits in
// the output register and does not block acceptance of the next item.
// Configuration writes are always ready and must only be made while idle.
module noisy_pendulum_symplectic_step_unit #(
    parameter int FRAC_BITS       = nps_pkg::FRAC_BITS_DEF,
    parameter int SINE_ITERATIONS = nps_pkg::SINE_ITERATIONS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  nps_pkg::in_item_t                      in_item,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output nps_pkg::out_item_t                     out_item,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [nps_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [nps_pkg::CFG_DATA_W-1:0]         cfg_data
);
    import nps_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_MUL_N = 9'b000000010,  // noise_scale * sample
        S_ADD_N = 9'b000000100,  // add noise, issue velocity * dt
        S_ADD_A = 9'b000001000,  // add angle increment
        S_ARG   = 9'b000010000,  // start the sine on angle + noise phase
        S_SINE  = 9'b000100000,  // wait for sine, then issue gain * sine
        S_MUL_T = 9'b001000000,  // issue t1 * dt
        S_ADD_V = 9'b010000000,  // subtract from velocity
        S_WRITE = 9'b100000000   // load the output register
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [GAIN_W-1:0]          gain_squared_reg;
    logic [DT_W-1:0]            time_step_reg;
    logic [SCALE_W-1:0]         noise_scale_reg;
    logic signed [STATE_W-1:0]  init_angle_reg;
    logic signed [STATE_W-1:0]  init_velocity_reg;
    logic signed [STATE_W-1:0]  init_noise_reg;
    logic [COUNT_W-1:0]         step_limit_reg;

    // Pendulum state.
    logic signed [STATE_W-1:0]  angle_reg;
    logic signed [STATE_W-1:0]  velocity_reg;
    logic signed [STATE_W-1:0]  noise_phase_reg;
    logic [COUNT_W-1:0]         step_counter_reg;
    logic                       done_reg;

    logic signed [NOISE_W-1:0]  sample_reg;
    logic                       out_valid_reg;
    out_item_t                  out_item_reg;

    logic                        in_accept;
    logic                        out_load;
    logic signed [MUL_A_W-1:0]   mul_a;
    logic signed [MUL_B_W-1:0]   mul_b;
    logic signed [PROD_W-1:0]    prod;
    logic signed [PROD_W:0]      sum_noise, sum_angle, sum_vel;
    logic signed [ARG_W-1:0]     sine_arg;
    logic                        sine_start;
    sine_stat_t                  sine_stat;
    logic signed [STATE_W-1:0]   sine_val;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_load  = (state_reg == S_WRITE) && (!out_valid_reg || !out_stall);

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_MUL_N:
            begin
                mul_a = MUL_A_W'(sample_reg);
                mul_b = MUL_B_W'($signed({1'b0, noise_scale_reg}));
            end
            S_ADD_N:
            begin
                mul_a = MUL_A_W'(velocity_reg);
                mul_b = MUL_B_W'($signed({1'b0, time_step_reg}));
            end
            S_SINE:
            begin
                mul_a = MUL_A_W'(sine_val);
                mul_b = MUL_B_W'($signed({1'b0, gain_squared_reg}));
            end
            S_MUL_T:
            begin
                mul_a = prod[MUL_A_W-1:0];
                mul_b = MUL_B_W'($signed({1'b0, time_step_reg}));
            end
            S_IDLE, S_ADD_A, S_ARG, S_ADD_V, S_WRITE:
            begin
                mul_a = '0;
                mul_b = '0;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    nps_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    assign sine_arg   = ARG_W'(angle_reg) + ARG_W'(noise_phase_reg);
    assign sine_start = (state_reg == S_ARG);

    nps_sine #(
        .FRAC_BITS       (FRAC_BITS),
        .SINE_ITERATIONS (SINE_ITERATIONS)
    ) u_sine (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sine_start),
        .arg   (sine_arg),
        .stat  (sine_stat),
        .sine  (sine_val)
    );

    assign sum_noise = (PROD_W+1)'(noise_phase_reg) + (PROD_W+1)'(prod);
    assign sum_angle = (PROD_W+1)'(angle_reg) + (PROD_W+1)'(prod);
    assign sum_vel   = (PROD_W+1)'(velocity_reg) - (PROD_W+1)'(prod);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept) begin
                    // Restart and ignored steps go straight to the output.
                    if (in_item.action == ACT_RESTART ||
                        step_counter_reg >= step_limit_reg) begin
                        state_next = S_WRITE;
                    end else begin
                        state_next = S_MUL_N;
                    end
                end
            end
            S_MUL_N: state_next = S_ADD_N;
            S_ADD_N: state_next = S_ADD_A;
            S_ADD_A: state_next = S_ARG;
            S_ARG:   state_next = S_SINE;
            S_SINE:  if (sine_stat.done) state_next = S_MUL_T;
            S_MUL_T: state_next = S_ADD_V;
            S_ADD_V: state_next = S_WRITE;
            S_WRITE: if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg         <= S_IDLE;
            gain_squared_reg  <= GAIN_SQUARED_RST;
            time_step_reg     <= TIME_STEP_RST;
            noise_scale_reg   <= NOISE_SCALE_RST;
            init_angle_reg    <= INIT_ANGLE_RST;
            init_velocity_reg <= INIT_VEL_RST;
            init_noise_reg    <= INIT_NOISE_RST;
            step_limit_reg    <= STEP_LIMIT_RST;
            angle_reg         <= '0;
            velocity_reg      <= '0;
            noise_phase_reg   <= '0;
            step_counter_reg  <= '0;
            done_reg          <= 1'b0;
            out_valid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_GAIN_SQUARED:        gain_squared_reg  <= cfg_data[GAIN_W-1:0];
                    REG_TIME_STEP:           time_step_reg     <= cfg_data[DT_W-1:0];
                    REG_NOISE_SCALE:         noise_scale_reg   <= cfg_data[SCALE_W-1:0];
                    REG_INITIAL_ANGLE:       init_angle_reg    <= cfg_data;
                    REG_INITIAL_VELOCITY:    init_velocity_reg <= cfg_data;
                    REG_INITIAL_NOISE_PHASE: init_noise_reg    <= cfg_data;
                    REG_STEP_LIMIT:          step_limit_reg    <= cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end

            if (in_accept) begin
                done_reg <= 1'b0;
                if (in_item.action == ACT_RESTART) begin
                    angle_reg        <= init_angle_reg;
                    velocity_reg     <= init_velocity_reg;
                    noise_phase_reg  <= init_noise_reg;
                    step_counter_reg <= '0;
                end else if (step_counter_reg >= step_limit_reg) begin
                    done_reg <= 1'b1;
                end
            end

            if (state_reg == S_ADD_N) begin
                noise_phase_reg <= sat32(sum_noise);
            end
            if (state_reg == S_ADD_A) begin
                angle_reg <= sat32(sum_angle);
            end
            if (state_reg == S_ADD_V) begin
                velocity_reg     <= sat32(sum_vel);
                step_counter_reg <= step_counter_reg + COUNT_W'(1);
            end

            // Drop the valid once taken; a new load wins.
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_valid_reg && !out_stall) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept) begin
            sample_reg <= in_item.noise_sample;
        end
        if (out_load) begin
            out_item_reg.angle       <= angle_reg;
            out_item_reg.velocity    <= velocity_reg;
            out_item_reg.noise_phase <= noise_phase_reg;
            out_item_reg.step_count  <= step_counter_reg;
            out_item_reg.done_res    <= done_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // An accepted item always blocks the input on the next cycle.
    a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> in_stall)
        else $error("input not stalled after an accepted item");

    // A result appears only out of the output load state.
    a_valid_from_write: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_WRITE))
        else $error("result valid without an output load");

    // The sine unit is started only when it is free.
    a_sine_free: assert property (@(posedge clk) disable iff (!rst_n)
        sine_start |-> !sine_stat.busy)
        else $error("sine started while busy");

    // The sine unit reports completion only while the sequencer waits for it.
    a_sine_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        sine_stat.done |-> (state_reg == S_SINE))
        else $error("sine finished outside the wait state");

endmodule

/* bench/noisy_pendulum_symplectic_step_unit_tb.sv */
// Self-checking bench for the noisy pendulum step unit: directed corners, then random runs.
// Depends on nps_pkg for the item types and register codes, and on the unit's RTL.
`timescale 1ns / 100ps

module noisy_pendulum_symplectic_step_unit_tb;
    import nps_pkg::*;

    // Fixed-point format and CORDIC length of the unit as instantiated.
    localparam int FRAC       = 16;
    localparam int ITERATIONS = 16;

    localparam logic [63:0] PI_FIXED60      = 64'h3243F6A8885A308D;
    localparam longint      CORDIC_GAIN_Q30 = 64'sd652032874;
    localparam longint      S32_MAX         = 64'sd2147483647;
    localparam longint      S32_MIN         = -64'sd2147483648;

    // DUT ports; every input starts at a known value.
    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    in_item_t   in_item   = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    out_item_t  out_item;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // Bench-side copy of the configuration, at reset values.
    logic [30:0]        k2_q       = 31'd16384;
    logic [16:0]        dt_q       = 17'd6554;
    logic [30:0]        eta_q      = 31'd2072;
    logic signed [31:0] theta0_q   = 32'sd102944;
    logic signed [31:0] omega0_q   = 32'sd0;
    logic signed [31:0] xi0_q      = 32'sd0;
    logic [19:0]        run_length = 20'd10000;

    // Bench-side copy of the pendulum state, all zero after reset.
    longint      theta_q     = 0;
    longint      omega_q     = 0;
    longint      xi_q        = 0;
    logic [19:0] steps_taken = '0;

    in_item_t  pending_items[$];
    out_item_t expected_states[$];
    int        items_queued   = 0;
    int        items_accepted = 0;
    int        mismatches     = 0;

    // Traffic shaping: quiet flags switch off random idling, rx_hold_left
    // forces a long receiver stall.
    bit quiet_tx     = 1'b0;
    bit quiet_rx     = 1'b0;
    int rx_hold_left = 0;

    noisy_pendulum_symplectic_step_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Pendulum predictor
    // ------------------------------------------------------------------

    function automatic longint clamp_s32(longint v);
        if (v > S32_MAX)
            return S32_MAX;
        if (v < S32_MIN)
            return S32_MIN;
        return v;
    endfunction

    // Arctangent of 2^-i in Q30.
    function automatic longint atan_step(int i);
        case (i)
            0:  return 843314857;
            1:  return 497837829;
            2:  return 263043837;
            3:  return 133525159;
            4:  return 67021687;
            5:  return 33543516;
            6:  return 16775851;
            7:  return 8388437;
            8:  return 4194283;
            9:  return 2097149;
            10: return 1048576;
            11: return 524288;
            12: return 262144;
            13: return 131072;
            14: return 65536;
            15: return 32768;
            default: return longint'(1) << (30 - i);
        endcase
    endfunction

    // Sine of a Q16.16 argument: reduce modulo 2*pi into [-pi, pi), fold into
    // [-pi/2, pi/2], then run the rotation-mode CORDIC in Q30.
    function automatic longint pendulum_sine(longint arg);
        longint pi_q, half_q, two_pi, r, x, y, z, dx, dy;
        pi_q   = longint'((PI_FIXED60 + (64'd1 << (59 - FRAC))) >> (60 - FRAC));
        half_q = longint'((PI_FIXED60 + (64'd1 << (60 - FRAC))) >> (61 - FRAC));
        two_pi = 2 * pi_q;
        r = arg % two_pi;
        if (r < 0)
            r += two_pi;
        if (r >= pi_q)
            r -= two_pi;
        if (r > half_q)
            r = pi_q - r;
        else if (r < -half_q)
            r = -pi_q - r;
        z = r * (longint'(1) << (30 - FRAC));
        x = CORDIC_GAIN_Q30;
        y = 0;
        for (int i = 0; i < ITERATIONS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= atan_step(i);
            end
            else
            begin
                x += dx;
                y -= dy;
                z += atan_step(i);
            end
        end
        return y >>> (30 - FRAC);
    endfunction

    // Apply one accepted item to the bench state and queue the state it yields.
    function automatic void advance_pendulum(in_item_t it);
        out_item_t res;
        longint    sample, kick, s, t1, t2;
        logic      done;
        done = 1'b0;
        if (it.action == ACT_RESTART)
        begin
            theta_q     = theta0_q;
            omega_q     = omega0_q;
            xi_q        = xi0_q;
            steps_taken = '0;
        end
        else if (steps_taken >= run_length)
        begin
            done = 1'b1;
        end
        else
        begin
            sample  = longint'($signed(it.noise_sample));
            kick    = (longint'(eta_q) * sample) >>> FRAC;
            xi_q    = clamp_s32(xi_q + kick);
            theta_q = clamp_s32(theta_q + ((omega_q * longint'(dt_q)) >>> FRAC));
            s       = pendulum_sine(theta_q + xi_q);
            t1      = (longint'(k2_q) * s) >>> FRAC;
            t2      = (t1 * longint'(dt_q)) >>> FRAC;
            omega_q = clamp_s32(omega_q - t2);
            steps_taken = steps_taken + 20'd1;
        end
        res.angle       = theta_q[31:0];
        res.velocity    = omega_q[31:0];
        res.noise_phase = xi_q[31:0];
        res.step_count  = steps_taken;
        res.done_res    = done;
        expected_states.push_back(res);
    endfunction

    // ------------------------------------------------------------------
    // Driver: present pending items, hold each one until the unit takes it.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                advance_pendulum(in_item);
                items_accepted++;
            end
            // Only pick the next item once the current one is gone; a stalled
            // item stays on the bus untouched.
            if (!in_valid || !in_stall)
            begin
                if (pending_items.size() != 0 && (quiet_tx || $urandom_range(99) >= 23))
                begin
                    in_item  <= pending_items.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each delivered result with the oldest expectation.
    // ------------------------------------------------------------------
    task automatic check_result(out_item_t got);
        out_item_t want;
        if (expected_states.size() == 0)
        begin
            $error("result with nothing outstanding: angle %0d, step_count %0d",
                   got.angle, got.step_count);
            mismatches++;
        end
        else
        begin
            want = expected_states.pop_front();
            if (got.angle !== want.angle)
            begin
                $error("angle: expected %0d, actual %0d", want.angle, got.angle);
                mismatches++;
            end
            if (got.velocity !== want.velocity)
            begin
                $error("velocity: expected %0d, actual %0d", want.velocity, got.velocity);
                mismatches++;
            end
            if (got.noise_phase !== want.noise_phase)
            begin
                $error("noise_phase: expected %0d, actual %0d",
                       want.noise_phase, got.noise_phase);
                mismatches++;
            end
            if (got.step_count !== want.step_count)
            begin
                $error("step_count: expected %0d, actual %0d",
                       want.step_count, got.step_count);
                mismatches++;
            end
            if (got.done_res !== want.done_res)
            begin
                $error("done_res: expected %0d, actual %0d", want.done_res, got.done_res);
                mismatches++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                check_result(out_item);
            out_stall <= (rx_hold_left > 0) || (!quiet_rx && $urandom_range(99) < 23);
        end
    end

    // Count down a long receiver hold-off, one cycle per edge.
    always @(posedge clk)
    begin
        if (rx_hold_left > 0)
            rx_hold_left <= rx_hold_left - 1;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers. Queue pushes happen on the falling edge so they never
    // race the driver; register writes are driven on the rising edge.
    // ------------------------------------------------------------------

    task automatic queue_step(logic signed [19:0] sample);
        in_item_t it;
        it.action       = ACT_STEP;
        it.noise_sample = sample;
        pending_items.push_back(it);
        items_queued++;
    endtask

    task automatic queue_restart();
        in_item_t it;
        it.action       = ACT_RESTART;
        it.noise_sample = 20'($urandom);
        pending_items.push_back(it);
        items_queued++;
    endtask

    // Mostly uniform in [-2, 2] in Q16.16, now and then any 20-bit pattern.
    function automatic logic signed [19:0] random_sample();
        if ($urandom_range(9) == 0)
            return 20'($urandom);
        return 20'(int'($urandom_range(0, 262144)) - 131072);
    endfunction

    // Block until every queued item is taken and every result has come back.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (items_accepted != items_queued || expected_states.size() != 0);
    endtask

    task automatic write_register(cfg_reg_t idx, logic [31:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        // Mirror the write into the predictor at the field widths.
        case (idx)
            REG_GAIN_SQUARED:        k2_q       = data[30:0];
            REG_TIME_STEP:           dt_q       = data[16:0];
            REG_NOISE_SCALE:         eta_q      = data[30:0];
            REG_INITIAL_ANGLE:       theta0_q   = data;
            REG_INITIAL_VELOCITY:    omega0_q   = data;
            REG_INITIAL_NOISE_PHASE: xi0_q      = data;
            REG_STEP_LIMIT:          run_length = data[19:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(logic [31:0] gain, logic [31:0] dt, logic [31:0] scale,
                                 logic [31:0] angle0, logic [31:0] vel0,
                                 logic [31:0] phase0, logic [31:0] limit);
        write_register(REG_GAIN_SQUARED, gain);
        write_register(REG_TIME_STEP, dt);
        write_register(REG_NOISE_SCALE, scale);
        write_register(REG_INITIAL_ANGLE, angle0);
        write_register(REG_INITIAL_VELOCITY, vel0);
        write_register(REG_INITIAL_NOISE_PHASE, phase0);
        write_register(REG_STEP_LIMIT, limit);
    endtask

    // Initial value near the swing range, sometimes any 32-bit pattern.
    function automatic logic [31:0] random_start();
        if ($urandom_range(4) == 0)
            return $urandom;
        return $urandom_range(0, 411774) - 205887;
    endfunction

    task automatic pick_settings();
        logic [31:0] gain, dt, scale, limit;
        case ($urandom_range(5))
            0:       gain = 32'h7FFF_FFFF;
            1:       gain = $urandom_range(0, 32'h7FFF_FFFF);
            default: gain = $urandom_range(0, 32'h0010_0000);
        endcase
        case ($urandom_range(7))
            0:       dt = $urandom_range(0, 131071);
            1:       dt = 65536;
            default: dt = $urandom_range(1, 65536);
        endcase
        if ($urandom_range(4) == 0)
            scale = $urandom_range(0, 32'h7FFF_FFFF);
        else
            scale = $urandom_range(0, 16384);
        case ($urandom_range(3))
            0:       limit = $urandom_range(0, 20'hFFFFF);
            1:       limit = $urandom_range(5, 60);
            default: limit = $urandom_range(60, 400);
        endcase
        load_settings(gain, dt, scale, random_start(), random_start(), random_start(), limit);
    endtask

    // A run opens with a restart, then mostly steps with the odd restart.
    task automatic queue_random_run(int count);
        @(negedge clk);
        queue_restart();
        for (int n = 1; n < count; n++)
        begin
            if ($urandom_range(49) == 0)
                queue_restart();
            else
                queue_step(random_sample());
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Steps on the zero state before any restart, with the sample extremes.
        @(negedge clk);
        queue_step(20'h00000);
        queue_step(20'h7FFFF);
        queue_step(20'h80000);
        queue_restart();
        repeat (3) queue_step(random_sample());
        wait_idle();

        // Zero step limit: the very first step is already done.
        load_settings(32'h7FFF_FFFF, 32'd65536, 32'h7FFF_FFFF,
                      32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'd0);
        @(negedge clk);
        queue_step(20'h00000);
        queue_restart();
        queue_step(20'h00005);
        wait_idle();

        // Largest gains and starting values: push every state into saturation,
        // then run past a short limit and restart out of done.
        write_register(REG_STEP_LIMIT, 32'd4);
        @(negedge clk);
        queue_restart();
        queue_step(20'h7FFFF);
        queue_step(20'h80000);
        queue_step(20'h00000);
        queue_step(20'h00064);
        queue_step(20'h00007);
        queue_restart();
        wait_idle();

        // Smallest values and the opposite starting corner.
        load_settings(32'd0, 32'd1, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF,
                      32'h8000_0000, 32'h000F_FFFF);
        @(negedge clk);
        queue_restart();
        queue_step(20'h7FFFF);
        queue_step(20'h80000);
        wait_idle();

        // Zero time step is taken as given.
        write_register(REG_TIME_STEP, 32'd0);
        @(negedge clk);
        queue_step(random_sample());
        queue_step(random_sample());
        wait_idle();

        // Random runs, each with fresh settings.
        for (int phase = 0; phase < 8; phase++)
        begin
            pick_settings();
            @(negedge clk);
            // No idling on either side for one whole run.
            quiet_tx = (phase == 2);
            quiet_rx = (phase == 2);
            // Hold off the receiver long enough for the unit to back up.
            if (phase == 4)
                rx_hold_left = 1000;
            if (phase == 6)
            begin
                // Stop the sender mid-run until everything has drained.
                queue_random_run(120);
                wait_idle();
                queue_random_run(120);
            end
            else
            begin
                queue_random_run(240);
            end
            wait_idle();
            quiet_tx = 1'b0;
            quiet_rx = 1'b0;
        end

        // Let any stray late result show up before the verdict.
        repeat (60) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog: abort a hung run.
    initial
    begin
        #30_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
